// ===== rtl/core/hud_pkg.sv =====
// ----------------------------------------------------------------------------
// hud_pkg
// Shared types and constants for the H4 UART packet deframer.
// ----------------------------------------------------------------------------
package hud_pkg;

  localparam int unsigned PosW = 17;

  typedef logic [PosW-1:0] pos_t;

  typedef enum logic [2:0] {
    KIND_CMD   = 3'd0,
    KIND_ACL   = 3'd1,
    KIND_SYNC  = 3'd2,
    KIND_EVENT = 3'd3,
    KIND_ISO   = 3'd4
  } kind_t;

  // packet indicator bytes
  localparam logic [7:0] IND_CMD   = 8'h01;
  localparam logic [7:0] IND_ACL   = 8'h02;
  localparam logic [7:0] IND_SYNC  = 8'h03;
  localparam logic [7:0] IND_EVENT = 8'h04;
  localparam logic [7:0] IND_ISO   = 8'h05;

  // reserved bits of the iso length high byte are dropped
  localparam logic [7:0] ISO_LEN_MASK = 8'h3f;

  // header lengths, indicator included
  localparam pos_t HDR_CMD   = pos_t'(4);
  localparam pos_t HDR_ACL   = pos_t'(5);
  localparam pos_t HDR_SYNC  = pos_t'(4);
  localparam pos_t HDR_EVENT = pos_t'(3);
  localparam pos_t HDR_ISO   = pos_t'(5);

  // byte positions of the length field
  localparam pos_t POS_LEN_EVENT = pos_t'(2);
  localparam pos_t POS_LEN_SHORT = pos_t'(3);
  localparam pos_t POS_LEN_LO    = pos_t'(3);
  localparam pos_t POS_LEN_HI    = pos_t'(4);

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       first;
    logic       last;
    logic       bad;
  } res_t;

endpackage

// ===== rtl/core/hud_parser.sv =====
// ----------------------------------------------------------------------------
// hud_parser
// Packet state tracker: decodes the indicator, captures the length field and
// marks the first and last word of each packet.
// ----------------------------------------------------------------------------
module hud_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        data_byte,
  output hud_pkg::res_t     res,
  output logic              at_start
);
  import hud_pkg::*;

  pos_t       pos_r, pos_nxt;
  pos_t       exp_r, exp_nxt;
  kind_t      kind_r, kind_nxt;
  logic [7:0] low_r, low_nxt;

  kind_t      dec_kind;
  pos_t       dec_hdr;
  logic       dec_bad;
  pos_t       pos_inc;

  assign at_start = (pos_r == '0);
  assign pos_inc  = pos_r + pos_t'(1);

  // indicator decode
  always_comb begin
    dec_kind = KIND_CMD;
    dec_hdr  = HDR_CMD;
    dec_bad  = 1'b0;
    case (data_byte)
      IND_CMD: begin
        dec_kind = KIND_CMD;
        dec_hdr  = HDR_CMD;
      end
      IND_ACL: begin
        dec_kind = KIND_ACL;
        dec_hdr  = HDR_ACL;
      end
      IND_SYNC: begin
        dec_kind = KIND_SYNC;
        dec_hdr  = HDR_SYNC;
      end
      IND_EVENT: begin
        dec_kind = KIND_EVENT;
        dec_hdr  = HDR_EVENT;
      end
      IND_ISO: begin
        dec_kind = KIND_ISO;
        dec_hdr  = HDR_ISO;
      end
      default: begin
        dec_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    pos_nxt   = pos_r;
    exp_nxt   = exp_r;
    kind_nxt  = kind_r;
    low_nxt   = low_r;
    res.data  = data_byte;
    res.kind  = KIND_CMD;
    res.first = 1'b0;
    res.last  = 1'b0;
    res.bad   = 1'b0;
    if (at_start) begin
      if (dec_bad) begin
        res.bad = 1'b1;
      end else begin
        kind_nxt  = dec_kind;
        exp_nxt   = dec_hdr;
        low_nxt   = '0;
        pos_nxt   = pos_t'(1);
        res.kind  = dec_kind;
        res.first = 1'b1;
      end
    end else begin
      res.kind = kind_r;
      case (kind_r)
        KIND_CMD: begin
          if (pos_r == POS_LEN_SHORT) exp_nxt = HDR_CMD + pos_t'(data_byte);
        end
        KIND_SYNC: begin
          if (pos_r == POS_LEN_SHORT) exp_nxt = HDR_SYNC + pos_t'(data_byte);
        end
        KIND_EVENT: begin
          if (pos_r == POS_LEN_EVENT) exp_nxt = HDR_EVENT + pos_t'(data_byte);
        end
        KIND_ACL: begin
          if (pos_r == POS_LEN_LO) low_nxt = data_byte;
          else if (pos_r == POS_LEN_HI) exp_nxt = HDR_ACL + pos_t'({data_byte, low_r});
        end
        KIND_ISO: begin
          if (pos_r == POS_LEN_LO) low_nxt = data_byte;
          else if (pos_r == POS_LEN_HI)
            exp_nxt = HDR_ISO + pos_t'({data_byte & ISO_LEN_MASK, low_r});
        end
        default: begin
        end
      endcase
      if (pos_inc >= exp_nxt) begin
        res.last = 1'b1;
        pos_nxt  = '0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      exp_r  <= '0;
      kind_r <= KIND_CMD;
      low_r  <= '0;
    end else if (step_en) begin
      pos_r  <= pos_nxt;
      exp_r  <= exp_nxt;
      kind_r <= kind_nxt;
      low_r  <= low_nxt;
    end
  end

endmodule

// ===== rtl/core/hci_uart_packet_deframer_top.sv =====
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer_top
// Splits an H4 UART byte stream into packets, one result word per input word.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_data_byte
//   out_    | output    | out_valid/out_stall| out_byte, kind, first, last, bad
//
// One word per cycle sustained while out_stall is low; an accepted word passes
// the input register, then the parser logic into the result register, to out_valid.
// The parser state advances only when a word moves into the result register.
// rst_n is synchronous and clears the pipeline valids and the packet state.
// out_stall backs up into in_stall in the same cycle once both stages are full.
// ----------------------------------------------------------------------------
module hci_uart_packet_deframer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic [2:0]           out_packet_kind,
  output logic                 out_first_of_packet,
  output logic                 out_last_of_packet,
  output logic                 out_bad_indicator
);
  import hud_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  res_t       out_r;

  logic       out_load;
  logic       s1_fire;
  logic       in_fire;
  res_t       res;
  logic       at_start;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_fire  = in_valid && !in_stall;

  hud_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_fire),
    .data_byte (s1_byte_r),
    .res       (res),
    .at_start  (at_start)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = out_r.data;
  assign out_packet_kind     = out_r.kind;
  assign out_first_of_packet = out_r.first;
  assign out_last_of_packet  = out_r.last;
  assign out_bad_indicator   = out_r.bad;

  // a bad indicator word carries no packet marks
  a_bad_no_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_indicator) |->
      (!out_first_of_packet && !out_last_of_packet && out_packet_kind == KIND_CMD))
    else $error("bad indicator word carries packet marks");

  // a first word is always a legal indicator
  a_first_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first_of_packet) |->
      (out_byte == IND_CMD || out_byte == IND_ACL || out_byte == IND_SYNC ||
       out_byte == IND_EVENT || out_byte == IND_ISO))
    else $error("first word is not a legal indicator");

  // after the last word the parser waits for an indicator
  a_last_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res.last) |=> at_start)
    else $error("parser not at packet start after last word");

  // an accepted indicator moves the parser into the packet
  a_first_leaves_start: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res.first) |=> !at_start)
    else $error("parser still at packet start after indicator");

endmodule
